// ----- rtl/indexed_insert_erase_list_top_macros.svh -----
// ----------------------------------------------------------------------------
// Indexed insert/erase list assertion macros
// Shorthand for the clocked, reset-qualified properties used in the list RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_ERASE_LIST_TOP_MACROS_SVH
`define INDEXED_INSERT_ERASE_LIST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IIEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IIEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list assertion failed");

`endif

// ----- rtl/iiel_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed insert/erase list package
// Operation and status codes and the shift command shared by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package iiel_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell: open a slot at the position, or close it.
    typedef struct packed {
        logic ins;
        logic ers;
    } t_shift_cmd;

endpackage

`default_nettype wire

// ----- rtl/iiel_cell.sv -----
// ----------------------------------------------------------------------------
// List storage cell
// Holds one entry and shifts it toward either neighbor on command.
// ----------------------------------------------------------------------------
`default_nettype none

module iiel_cell
    import iiel_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int CNT_W      = 5,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire t_shift_cmd            i_cmd,
    input  wire logic [CNT_W-1:0]      i_pos,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic      [DATA_WIDTH-1:0] o_hit_data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_IDX == i_pos) begin
                n_data = i_value;
            end else if (MY_IDX > i_pos) begin
                n_data = i_left;
            end
        end else if (i_cmd.ers) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_hit_data = (MY_IDX == i_pos) ? r_data : '0;

endmodule

`default_nettype wire

// ----- rtl/iiel_ctrl.sv -----
// ----------------------------------------------------------------------------
// List controller
// Decodes each word, keeps the fill count and drives the cell shift command.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_insert_erase_list_top_macros.svh"

module iiel_ctrl
    import iiel_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [OP_W-1:0]  i_opcode,
    input  wire logic [CNT_W-1:0] i_position,
    output t_shift_cmd            o_cmd,
    output logic      [CNT_W-1:0] o_pos,
    output logic                  o_rd_en,
    output t_status               o_status,
    output logic      [CNT_W-1:0] o_count
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_shift_cmd       w_cmd;
    logic             w_full;

    assign w_full = (r_count == FULL_CNT);

    always_comb begin
        n_count  = r_count;
        w_cmd    = '0;
        o_pos    = i_position;
        o_rd_en  = 1'b0;
        o_status = ST_OK;
        case (t_opcode'(i_opcode))
            OP_PUSH: begin
                o_pos = r_count;
                if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_INSERT: begin
                if (i_position > r_count) begin
                    o_status = ST_RANGE;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_ERASE: begin
                if (i_position >= r_count) begin
                    o_status = ST_RANGE;
                end else begin
                    w_cmd.ers = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_READ: begin
                if (i_position >= r_count) begin
                    o_status = ST_RANGE;
                end else begin
                    o_rd_en = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Cells only move on an accepted word.
    assign o_cmd.ins = w_cmd.ins & i_accept;
    assign o_cmd.ers = w_cmd.ers & i_accept;
    assign o_count   = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    `IIEL_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `IIEL_ASSERT_SAME(a_cmd_excl, i_clk, i_rst_n, 1'b1, !(o_cmd.ins && o_cmd.ers))
    `IIEL_ASSERT_SAME(a_full_only_full, i_clk, i_rst_n, o_status == ST_FULL, w_full)
    `IIEL_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, o_cmd.ins, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

// ----- rtl/indexed_insert_erase_list_top.sv -----
// Each result word is registered and appears in the cycle after its word is accepted.
// Throughput: one word per cycle unless master stalls; all cells shift in the same cycle.
// The slave side stalls only while a finished result is held and the master side stalls.
// Reset (i_rst_n low, synchronous) empties the list and drops the output valid.
// Stored entries are not cleared; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
// Indexed insert/erase list top level
// Fixed-capacity ordered array built as a row of shifting cells.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_erase_list_top
    import iiel_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // Slave side: tdata = opcode, position, item_value (lowest bits first).
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [((OP_W + $clog2(DEPTH + 1) + DATA_WIDTH + 7) / 8) * 8 - 1:0]
                                                        i_s_axis_tdata,
    // Master side: tdata = read_data, count, is_empty, status (lowest bits first).
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 1 + ST_W + 7) / 8) * 8 - 1:0]
                                                        o_m_axis_tdata
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OUT_BITS = DATA_WIDTH + CNT_W + 1 + ST_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int POS_LO   = OP_W;
    localparam int VAL_LO   = OP_W + CNT_W;

    // Input word fields.
    logic [OP_W-1:0]       w_opcode;
    logic [CNT_W-1:0]      w_position;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_accept;

    // Controller outputs.
    t_shift_cmd            w_cmd;
    logic [CNT_W-1:0]      w_pos;
    logic                  w_rd_en;
    t_status               w_status;
    logic [CNT_W-1:0]      w_count;

    // Cell row.
    logic [DATA_WIDTH-1:0] w_cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_cell_hit  [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd_any;
    logic [DATA_WIDTH-1:0] w_read_data;

    // Output register.
    logic                  r_m_valid;
    logic [OUT_W-1:0]      r_m_data;

    assign w_opcode   = i_s_axis_tdata[OP_W-1:0];
    assign w_position = i_s_axis_tdata[POS_LO +: CNT_W];
    assign w_value    = i_s_axis_tdata[VAL_LO +: DATA_WIDTH];

    // A new word is taken whenever the output register is free or being drained.
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    iiel_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_opcode   (w_opcode),
        .i_position (w_position),
        .o_cmd      (w_cmd),
        .o_pos      (w_pos),
        .o_rd_en    (w_rd_en),
        .o_status   (w_status),
        .o_count    (w_count)
    );

    // Each cell sees its lower neighbor (insert shifts up) and its upper
    // neighbor (erase shifts down). The ends are tied off; what they pull in
    // lands above the fill count and is never read.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        iiel_cell #(
            .IDX        (g),
            .CNT_W      (CNT_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_pos      (w_pos),
            .i_value    (w_value),
            .i_left     ((g == 0) ? w_value : w_cell_data[(g == 0) ? 0 : g - 1]),
            .i_right    ((g == DEPTH - 1) ? w_cell_data[g]
                                          : w_cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .o_data     (w_cell_data[g]),
            .o_hit_data (w_cell_hit[g])
        );
    end

    // Every cell but the addressed one drives a zero hit word, so an OR picks it out.
    always_comb begin
        w_rd_any = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_any = w_rd_any | w_cell_hit[k];
        end
    end

    assign w_read_data = w_rd_en ? w_rd_any : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_m_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= OUT_W'({w_status, (w_count == '0), w_count, w_read_data});
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire
